/* hw/rtl/video_scan_address_generator_top_macros.svh */
// Assertion macros shared by the video scan address generator.
`ifndef VIDEO_SCAN_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define VIDEO_SCAN_ADDRESS_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vsag_pkg.sv */
package vsag_pkg;

  localparam int unsigned H_W    = 7;
  localparam int unsigned V_W    = 9;
  localparam int unsigned ADDR_W = 15;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Scan counter limits
  localparam logic [H_W-1:0] H_FIRST   = 7'h40;
  localparam logic [H_W-1:0] H_LAST    = 7'h7F;
  localparam logic [V_W-1:0] V_RESET   = 9'h100;
  localparam logic [V_W-1:0] V_LAST    = 9'h1FF;
  localparam logic [V_W-1:0] V_WRAP    = 9'h0FA;

  // Scrambling adder offset (0x68 >> 3)
  localparam logic [3:0] MID_BASE = 4'hD;

  // Page select codes placed at the page bits of an address
  localparam logic [1:0] PAGE_ONE = 2'b01;
  localparam logic [1:0] PAGE_TWO = 2'b10;

  // Register indexes
  localparam logic [2:0] REG_GRAPHICS = 3'd0;
  localparam logic [2:0] REG_HIRES    = 3'd1;
  localparam logic [2:0] REG_MIXED    = 3'd2;
  localparam logic [2:0] REG_PAGE_TWO = 3'd3;
  localparam logic [2:0] REG_STORE_80 = 3'd4;

  typedef struct packed {
    logic graphics_on;
    logic hires_on;
    logic mixed_on;
    logic page_two;
    logic store_80;
  } mode_t;

  typedef struct packed {
    logic [H_W-1:0] horiz;
    logic [V_W-1:0] vert;
  } scan_pos_t;

  typedef struct packed {
    logic [ADDR_W-1:0] video_address;
    logic [H_W-1:0]    horiz_count;
    logic [V_W-1:0]    vert_count;
    logic              text_window;
  } result_t;

endpackage

/* hw/rtl/vsag_scan.sv */
module vsag_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                advance,
  output vsag_pkg::scan_pos_t pos_nxt,
  output vsag_pkg::scan_pos_t pos_r
);
  import vsag_pkg::*;

  logic [H_W-1:0] h_inc;
  logic [V_W-1:0] v_inc;

  assign h_inc = pos_r.horiz + 7'd1;
  assign v_inc = pos_r.vert + 9'd1;

  // Step the scan position for an item that asks to advance
  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      if (pos_r.horiz == '0) begin
        pos_nxt.horiz = H_FIRST;
      end else begin
        pos_nxt.horiz = h_inc;
        if (pos_r.horiz == H_LAST) begin
          pos_nxt.vert = (pos_r.vert == V_LAST) ? V_WRAP : v_inc;
        end
      end
    end
  end

  // Hold the position between accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r.horiz <= '0;
      pos_r.vert  <= V_RESET;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hw/rtl/vsag_addr.sv */
module vsag_addr (
  input  vsag_pkg::scan_pos_t pos,
  input  vsag_pkg::mode_t     mode,
  output vsag_pkg::result_t   result
);
  import vsag_pkg::*;

  logic       window;
  logic       second;
  logic       use_hires;
  logic [3:0] mid;
  logic [9:0] base;
  logic [1:0] page;

  // Text window covers rows 0x1A0..0x1BF and 0x1E0..0x1FF
  assign window = pos.vert[8] & pos.vert[7] & pos.vert[5];

  // Scrambling adder on A6..A3
  assign mid  = MID_BASE + {1'b0, pos.horiz[5:3]}
              + {pos.vert[7], pos.vert[6], pos.vert[7], pos.vert[6]};
  assign base = {pos.vert[5:3], mid, pos.horiz[2:0]};

  assign second    = mode.page_two & ~mode.store_80;
  assign use_hires = mode.graphics_on & mode.hires_on & ~(mode.mixed_on & window);
  assign page      = second ? PAGE_TWO : PAGE_ONE;

  // Place the page bits above the row or line bits
  always_comb begin
    if (use_hires) begin
      result.video_address = {page, pos.vert[2:0], base};
    end else begin
      result.video_address = {3'b000, page, base};
    end
    result.horiz_count = pos.horiz;
    result.vert_count  = pos.vert;
    result.text_window = window;
  end

endmodule

/* hw/rtl/vsag_obuf.sv */
module vsag_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vsag_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vsag_pkg::result_t out_data
);
  import vsag_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;

  assign push_ready = ~skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  // Control: main stage feeds the port, skid catches an item during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!main_valid_r || out_ready) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (main_valid_r && out_ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid_r || out_ready) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (main_valid_r && out_ready && skid_valid_r) begin
      main_r <= skid_r;
    end
  end

endmodule

/* hw/rtl/video_scan_address_generator_top.sv */
// Video scan address generator. Each accepted item is one video-cycle tick:
// with in_advance high the horizontal counter steps (0, then 0x40..0x7F,
// wrapping to 0 and stepping the vertical counter 0x100..0x1FF, wrap 0xFA),
// and the block returns exactly one result with the display memory address
// for the new position, the two counters and the text-window flag. One item
// is accepted every clock while in_ready is high; its result is formed
// combinationally by the counter-step and address-forming logic and is
// registered in the output register. A second output entry absorbs one item
// while the output is stalled, so in_ready drops only when both entries hold
// results. Mode bits sit in APB registers at byte
// addresses 0x00 (graphics), 0x04 (hires), 0x08 (mixed), 0x0C (page 2) and
// 0x10 (80-column store); bit 0 is used and they reset to zero.
`include "video_scan_address_generator_top_macros.svh"

module video_scan_address_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_advance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vsag_pkg::ADDR_W-1:0] out_video_address,
  output logic [vsag_pkg::H_W-1:0]    out_horiz_count,
  output logic [vsag_pkg::V_W-1:0]    out_vert_count,
  output logic                        out_text_window,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vsag_pkg::APB_AW-1:0] paddr,
  input  logic [vsag_pkg::APB_DW-1:0] pwdata,
  output logic [vsag_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import vsag_pkg::*;

  mode_t     mode_r;
  logic      cfg_write;
  logic [2:0] reg_idx;
  logic      accept;
  scan_pos_t pos_nxt;
  scan_pos_t pos_r;
  result_t   result;
  result_t   out_data;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GRAPHICS: mode_r.graphics_on <= pwdata[0];
        REG_HIRES:    mode_r.hires_on    <= pwdata[0];
        REG_MIXED:    mode_r.mixed_on    <= pwdata[0];
        REG_PAGE_TWO: mode_r.page_two    <= pwdata[0];
        REG_STORE_80: mode_r.store_80    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_GRAPHICS: prdata[0] = mode_r.graphics_on;
      REG_HIRES:    prdata[0] = mode_r.hires_on;
      REG_MIXED:    prdata[0] = mode_r.mixed_on;
      REG_PAGE_TWO: prdata[0] = mode_r.page_two;
      REG_STORE_80: prdata[0] = mode_r.store_80;
      default:      prdata    = '0;
    endcase
  end

  assign accept = in_valid & in_ready;

  vsag_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .advance (in_advance),
    .pos_nxt (pos_nxt),
    .pos_r   (pos_r)
  );

  vsag_addr u_addr (
    .pos    (pos_nxt),
    .mode   (mode_r),
    .result (result)
  );

  vsag_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_video_address = out_data.video_address;
  assign out_horiz_count   = out_data.horiz_count;
  assign out_vert_count    = out_data.vert_count;
  assign out_text_window   = out_data.text_window;

  // Checks on the scan state
`VSAG_ASSERT_NOW(a_horiz_range, pos_r.horiz != '0, pos_r.horiz[6], "horizontal counter left its range")
`VSAG_ASSERT_NOW(a_vert_range, 1'b1, pos_r.vert >= V_WRAP, "vertical counter below wrap value")
`VSAG_ASSERT_NEXT(a_hold_pos, rst_n && accept && !in_advance, $stable(pos_r), "position moved without advance")

endmodule

/* sim/tb_video_scan_address_generator_top.sv */
`timescale 1ns / 100ps

module tb_video_scan_address_generator_top;
  import vsag_pkg::*;

  localparam int unsigned NUM_MODE_REGS   = 5;
  localparam int unsigned LAST_REG_SLOT   = 7;
  localparam int unsigned IDLE_PCT        = 30;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned MAX_PRINTS      = 100;
  localparam int unsigned MID_OFFSET      = 'h68;
  localparam int unsigned LORES_PAGE      = 'h400;
  localparam int unsigned HIRES_PAGE      = 'h2000;
  localparam int unsigned TEXT_WIN_TOP    = 'h1A0;
  localparam int unsigned TEXT_WIN_TOP_END = 'h1C0;
  localparam int unsigned TEXT_WIN_BOTTOM = 'h1E0;

  // one directed stimulus row; exp is used only when check is set
  typedef struct packed {
    logic    set_mode;
    mode_t   mode;
    logic    advance;
    logic    check;
    result_t exp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_advance = 1'b0;
  logic              out_ready = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  logic              in_ready;
  logic              out_valid;
  logic [ADDR_W-1:0] out_video_address;
  logic [H_W-1:0]    out_horiz_count;
  logic [V_W-1:0]    out_vert_count;
  logic              out_text_window;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // scan state and display mode as the block should hold them
  mode_t          disp_mode = '0;
  logic [H_W-1:0] scan_h = '0;
  logic [V_W-1:0] scan_v = V_RESET;

  result_t     pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  logic        steady_run = 1'b0;

  video_scan_address_generator_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_advance        (in_advance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_video_address (out_video_address),
    .out_horiz_count   (out_horiz_count),
    .out_vert_count    (out_vert_count),
    .out_text_window   (out_text_window),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // address, counters and window flag for one scan position
  function automatic result_t form_result(input logic [H_W-1:0] h, input logic [V_W-1:0] v,
                                          input mode_t m);
    int unsigned hi, vi, row_mix, mid, base, addr;
    logic        window, second, use_hires;
    result_t     r;
    hi = h;
    vi = v;
    window = (vi >= TEXT_WIN_TOP && vi < TEXT_WIN_TOP_END) || vi >= TEXT_WIN_BOTTOM;
    row_mix = ((vi & 'hC0) >> 1) | ((vi & 'hC0) >> 3);
    mid = (MID_OFFSET + (hi & 'h38) + row_mix) & 'h78;
    base = (hi & 'h7) | mid | ((vi & 'h38) << 4);
    second = m.page_two && !m.store_80;
    use_hires = m.graphics_on && m.hires_on && !(m.mixed_on && window);
    if (use_hires) begin
      addr = (base | HIRES_PAGE | ((vi & 'h7) << 10)) + (second ? HIRES_PAGE : 0);
    end else begin
      addr = (base | LORES_PAGE) + (second ? LORES_PAGE : 0);
    end
    r.video_address = addr[ADDR_W-1:0];
    r.horiz_count = h;
    r.vert_count = v;
    r.text_window = window;
    return r;
  endfunction

  // advance the scan counters by one video cycle
  task automatic step_scan();
    if (scan_h != '0) begin
      if (scan_h == H_LAST) begin
        scan_h = '0;
        scan_v = (scan_v == V_LAST) ? V_WRAP : scan_v + 1'b1;
      end else begin
        scan_h = scan_h + 1'b1;
      end
    end else begin
      scan_h = H_FIRST;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want_v);
  endtask

  function automatic dir_row_t dir_row(input logic set_mode, input mode_t m, input logic adv,
                                       input logic chk, input result_t exp);
    dir_row_t r;
    r.set_mode = set_mode;
    r.mode = m;
    r.advance = adv;
    r.check = chk;
    r.exp = exp;
    return r;
  endfunction

  // present one item, hold it until accepted, then record its expected result
  task automatic send_item(input logic adv, input logic use_fixed, input result_t fixed);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_advance <= adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (adv) step_scan();
    if (use_fixed) pending_results.push_back(fixed);
    else pending_results.push_back(form_result(scan_h, scan_v, disp_mode));
  endtask

  // drop valid and wait until every result is out and the pipe is empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then the bus returns to idle
  task automatic reg_write(input logic [2:0] idx, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GRAPHICS: disp_mode.graphics_on = data[0];
      REG_HIRES:    disp_mode.hires_on = data[0];
      REG_MIXED:    disp_mode.mixed_on = data[0];
      REG_PAGE_TWO: disp_mode.page_two = data[0];
      REG_STORE_80: disp_mode.store_80 = data[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // write all mode registers with noise in the unused bits
  task automatic load_mode(input mode_t m);
    logic [APB_DW-1:0] noise;
    logic [2:0]        spare_idx;
    settle_block();
    noise = $urandom();
    reg_write(REG_GRAPHICS, {noise[APB_DW-1:1], m.graphics_on});
    noise = $urandom();
    reg_write(REG_HIRES, {noise[APB_DW-1:1], m.hires_on});
    noise = $urandom();
    reg_write(REG_MIXED, {noise[APB_DW-1:1], m.mixed_on});
    noise = $urandom();
    reg_write(REG_PAGE_TWO, {noise[APB_DW-1:1], m.page_two});
    noise = $urandom();
    reg_write(REG_STORE_80, {noise[APB_DW-1:1], m.store_80});
    // a slot past the register list must not disturb anything
    if ($urandom_range(0, 2) == 0) begin
      spare_idx = 3'($urandom_range(NUM_MODE_REGS, LAST_REG_SLOT));
      reg_write(spare_idx, $urandom());
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, address", out_video_address, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_video_address !== want.video_address)
            report_mismatch("video_address", out_video_address, want.video_address);
          if (out_horiz_count !== want.horiz_count)
            report_mismatch("horiz_count", out_horiz_count, want.horiz_count);
          if (out_vert_count !== want.vert_count)
            report_mismatch("vert_count", out_vert_count, want.vert_count);
          if (out_text_window !== want.text_window)
            report_mismatch("text_window", out_text_window, want.text_window);
        end
      end
      out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    // mode literals are {graphics, hires, mixed, page_two, store_80};
    // results are {address, horiz, vert, window}
    dir_rows.push_back(dir_row(0, '0, 0, 1, result_t'({15'h0468, 7'h00, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(0, '0, 1, 1, result_t'({15'h0468, 7'h40, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(0, '0, 1, 1, result_t'({15'h0469, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b00010), 0, 1,
                               result_t'({15'h0869, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b00011), 0, 1,
                               result_t'({15'h0469, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b11000), 0, 1,
                               result_t'({15'h2069, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b11010), 0, 1,
                               result_t'({15'h4069, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b11100), 0, 1,
                               result_t'({15'h2069, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b10100), 0, 1,
                               result_t'({15'h0469, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b11111), 0, 1,
                               result_t'({15'h2069, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(1, mode_t'(5'b10010), 0, 1,
                               result_t'({15'h0869, 7'h41, 9'h100, 1'b0})));
    dir_rows.push_back(dir_row(0, '0, 1, 0, '0));
    dir_rows.push_back(dir_row(0, '0, 1, 0, '0));
    dir_rows.push_back(dir_row(1, mode_t'(5'b11010), 1, 0, '0));
    dir_rows.push_back(dir_row(0, '0, 1, 0, '0));
    dir_rows.push_back(dir_row(0, '0, 0, 0, '0));
    dir_rows.push_back(dir_row(1, mode_t'(5'b01000), 1, 0, '0));
    dir_rows.push_back(dir_row(0, '0, 1, 0, '0));
    dir_rows.push_back(dir_row(1, mode_t'(5'b00000), 1, 0, '0));
    dir_rows.push_back(dir_row(0, '0, 1, 0, '0));

    // hold reset, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_mode) load_mode(dir_rows[i].mode);
      send_item(dir_rows[i].advance, dir_rows[i].check, dir_rows[i].exp);
    end

    // all-clear, all-set and random modes with a random mix of advance and hold, one stretch without idling
    for (int p = 0; p < 10; p++) begin
      if (p == 0) load_mode('0);
      else if (p == 1) load_mode('1);
      else load_mode(mode_t'($urandom_range(0, 31)));
      steady_run = (p >= 4 && p < 6);
      repeat (75) send_item($urandom_range(0, 3) != 0, 1'b0, '0);
    end
    steady_run = 1'b0;

    settle_block();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
